[rtl/core/exu_pkg.sv]
// Shared types and constants for the expert usage table with top-k query.
// Used by exu_div and expert_usage_table_topk_core.
`default_nettype none
package exu_pkg;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_DECAY   = 2'd1,
        CMD_TOPK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_LAYERS  = 2'd0;
    localparam logic [1:0] CFG_EXPERTS = 2'd1;
    localparam logic [1:0] CFG_DECAY   = 2'd2;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [31:0] MASS_MAX  = 32'hFFFF_FFFF;
    localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        t_cmd        cmd;
        logic [4:0]  layer;
        logic [5:0]  expert;
        logic [15:0] weight;
        logic [6:0]  k;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [5:0]  expert_id;
        logic [16:0] score;
        logic [39:0] layer_mass;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RESP, S_OBS_WR,
        S_DM_RD, S_DM_MUL, S_DM_WR,
        S_DT_RD, S_DT_LO, S_DT_HI, S_DT_WR,
        S_TK_TOT, S_TK_SCAN, S_TK_END, S_TK_DEC, S_TK_DIV
    } t_state;

    function automatic t_out_item mk_res(logic status, logic found, logic [5:0] id,
                                         logic [16:0] score, logic [39:0] mass,
                                         logic last);
        t_out_item r;
        r.status     = status;
        r.found      = found;
        r.expert_id  = id;
        r.score      = score;
        r.layer_mass = mass;
        r.last       = last;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/exu_div.sv]
// Score divider: floor(num * 2^16 / den) clamped to 1.0 in Q1.16.
// Restoring division, one quotient bit per cycle; uses exu_pkg.
`default_nettype none
module exu_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [39:0] i_den,
    output logic             o_done,
    output logic [16:0]      o_quot
);
    import exu_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [40:0] r_rem;
    logic [39:0] r_den;
    logic [16:0] r_q;
    logic [40:0] rem2;

    assign rem2 = {r_rem[39:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if ({8'd0, i_num} >= i_den) begin
                    // share of one or more saturates at 1.0
                    r_q    <= ONE_Q16;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {9'd0, i_num};
                    r_q    <= '0;
                    r_cnt  <= 5'd16;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (rem2 >= {1'b0, r_den}) begin
                    r_rem <= rem2 - {1'b0, r_den};
                    r_q   <= {r_q[15:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[15:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[rtl/core/expert_usage_table_topk_core.sv]
// Per-layer expert usage histogram: observe, decay, top-k query, clear.
// Top level; uses exu_pkg and exu_div.
//
// Input beats carry one command; output beats carry results (top-k gives one
// beat per ranked expert, the final beat has last set). Both channels use
// valid/stall; configuration writes use valid/ready with ready tied high.
// One command at a time: input stall stays high until the command's last
// result is in the output register. The output register lets the next
// command start while the previous result waits on a stalled receiver.
// Observe: accept, then read-modify-write of entry and total.
// Decay: accept, then read, multiply and write each table entry over
//   MAX_LAYERS * 2^ceil(log2(MAX_EXPERTS)) entries, then read each layer
//   40-bit total, multiply both 20-bit halves and write it, then the result.
// Top-k: accept and read the layer total, then per rank a scan of experts_in_use
//   table entries, then the bit-serial divider.
// Clear: one table entry per cycle over the whole table.
// After reset the same clearing pass runs, and no input beat is accepted
// until it ends.
// A stalled receiver holds the output register; the engine waits only to load it.
`default_nettype none
module expert_usage_table_topk_core #(
    parameter int MAX_LAYERS  = 32,
    parameter int MAX_EXPERTS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire exu_pkg::t_in_item   i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output exu_pkg::t_out_item       o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [16:0]         i_cfg_data
);
    import exu_pkg::*;

    localparam int EW        = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
    localparam int LW        = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int AW        = LW + EW;
    localparam int MDEPTH    = MAX_LAYERS * (1 << EW);
    localparam int MASS_LAST = MDEPTH - 1;
    localparam int LAYER_LAST = MAX_LAYERS - 1;

    // configuration
    logic [5:0]  r_cfg_layers;
    logic [6:0]  r_cfg_experts;
    logic [16:0] r_cfg_decay;
    logic [6:0]  ne;

    // memories
    logic [31:0] r_mass_mem [MDEPTH];
    logic [39:0] r_tot_mem  [MAX_LAYERS];
    logic [31:0] r_mrd;
    logic [39:0] r_trd;
    logic          mass_we, tot_we;
    logic [AW-1:0] mass_wa, mass_ra;
    logic [LW-1:0] tot_wa, tot_ra;
    logic [31:0]   mass_wd;
    logic [39:0]   tot_wd;

    // control and datapath
    t_state        r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    t_out_item     r_res, n_res;
    logic          r_clr_resp;
    logic [LW-1:0] r_layer;
    logic [EW-1:0] r_expert;
    logic [15:0]   r_weight;
    logic [6:0]    r_kk;
    logic [39:0]   r_total;
    logic [48:0]   r_prod;
    logic [36:0]   r_plo, r_phi;
    logic [19:0]   r_thi;
    logic [6:0]    r_e, r_n;
    logic          r_pv;
    logic [EW-1:0] r_pe;
    logic          r_have;
    logic [EW-1:0] r_best;
    logic [31:0]   r_best_mass;
    logic [MAX_EXPERTS-1:0] r_sel;
    t_out_item     r_pend;
    logic          r_pend_v;
    logic          r_ovalid;
    t_out_item     r_out;

    logic          accept, slot_free, out_ld;
    t_out_item     out_d;
    logic          layer_ok, expert_ok;
    logic [6:0]    k_clip;
    logic [32:0]   m_sum;
    logic [40:0]   t_sum;
    logic [31:0]   m_new;
    logic [39:0]   t_new;
    logic [56:0]   dt_sum;
    logic          div_start, div_done;
    logic [16:0]   div_quot;
    logic          tk_final;
    t_out_item     tk_item;

    assign ne = (r_cfg_experts > 7'(MAX_EXPERTS)) ? 7'(MAX_EXPERTS) : r_cfg_experts;
    assign layer_ok  = ({1'b0, i_in.layer} < r_cfg_layers) && (32'(i_in.layer) < MAX_LAYERS);
    assign expert_ok = ({1'b0, i_in.expert} < ne);
    assign k_clip    = (i_in.k > ne) ? ne : i_in.k;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_ovalid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign m_sum  = {1'b0, r_mrd} + {17'd0, r_weight};
    assign t_sum  = {1'b0, r_trd} + {25'd0, r_weight};
    assign m_new  = m_sum[32] ? MASS_MAX : m_sum[31:0];
    assign t_new  = t_sum[40] ? TOTAL_MAX : t_sum[39:0];
    assign dt_sum = {r_phi, 20'd0} + {20'd0, r_plo};

    assign tk_final = ((r_n + 7'd1) == r_kk);
    assign tk_item  = mk_res(1'b0, 1'b1, 6'(r_best), div_quot, r_total, tk_final);

    exu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_best_mass),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // read addresses
    always_comb begin
        unique case (r_state)
            S_IDLE:    mass_ra = {LW'(i_in.layer), EW'(i_in.expert)};
            S_OBS_WR:  mass_ra = {r_layer, r_expert};
            S_TK_SCAN: mass_ra = {r_layer, r_e[EW-1:0]};
            default:   mass_ra = r_addr;
        endcase
        unique case (r_state)
            S_IDLE:  tot_ra = LW'(i_in.layer);
            S_DT_RD: tot_ra = r_addr[LW-1:0];
            default: tot_ra = r_layer;
        endcase
    end

    // next state, memory writes, output load
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_res     = r_res;
        mass_we   = 1'b0;
        mass_wa   = r_addr;
        mass_wd   = '0;
        tot_we    = 1'b0;
        tot_wa    = r_layer;
        tot_wd    = '0;
        out_ld    = 1'b0;
        out_d     = r_res;
        div_start = 1'b0;
        unique case (r_state)
            S_CLR: begin
                mass_we = 1'b1;
                if (r_addr[EW-1:0] == '0) begin
                    tot_we = 1'b1;
                    tot_wa = r_addr[AW-1:EW];
                end
                if (r_addr == AW'(MASS_LAST)) begin
                    n_res   = mk_res(1'b0, 1'b0, '0, '0, '0, 1'b1);
                    n_state = r_clr_resp ? S_RESP : S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    unique case (i_in.cmd)
                        CMD_OBSERVE: begin
                            if (layer_ok && expert_ok) begin
                                n_state = S_OBS_WR;
                            end else begin
                                n_res   = mk_res(1'b1, 1'b0, '0, '0, '0, 1'b1);
                                n_state = S_RESP;
                            end
                        end
                        CMD_DECAY: begin
                            if (r_cfg_decay > ONE_Q16) begin
                                n_res   = mk_res(1'b1, 1'b0, '0, '0, '0, 1'b1);
                                n_state = S_RESP;
                            end else begin
                                n_state = S_DM_RD;
                            end
                        end
                        CMD_TOPK: begin
                            if (layer_ok && (i_in.k != 7'd0)) begin
                                n_state = S_TK_TOT;
                            end else begin
                                n_res   = mk_res(1'b1, 1'b0, '0, '0, '0, 1'b1);
                                n_state = S_RESP;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    out_ld  = 1'b1;
                    out_d   = r_res;
                    n_state = S_IDLE;
                end
            end
            S_OBS_WR: begin
                if (slot_free) begin
                    mass_we = 1'b1;
                    mass_wa = {r_layer, r_expert};
                    mass_wd = m_new;
                    tot_we  = 1'b1;
                    tot_wa  = r_layer;
                    tot_wd  = t_new;
                    out_ld  = 1'b1;
                    out_d   = mk_res(1'b0, 1'b0, '0, '0, t_new, 1'b1);
                    n_state = S_IDLE;
                end
            end
            S_DM_RD:  n_state = S_DM_MUL;
            S_DM_MUL: n_state = S_DM_WR;
            S_DM_WR: begin
                mass_we = 1'b1;
                mass_wd = r_prod[47:16];
                if (r_addr == AW'(MASS_LAST)) begin
                    n_addr  = '0;
                    n_state = S_DT_RD;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_DM_RD;
                end
            end
            S_DT_RD: n_state = S_DT_LO;
            S_DT_LO: n_state = S_DT_HI;
            S_DT_HI: n_state = S_DT_WR;
            S_DT_WR: begin
                tot_we = 1'b1;
                tot_wa = r_addr[LW-1:0];
                tot_wd = dt_sum[55:16];
                if (r_addr == AW'(LAYER_LAST)) begin
                    n_res   = mk_res(1'b0, 1'b0, '0, '0, '0, 1'b1);
                    n_state = S_RESP;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_state = S_DT_RD;
                end
            end
            S_TK_TOT: begin
                if ((r_trd == '0) || (r_kk == 7'd0)) begin
                    n_res   = mk_res(1'b0, 1'b0, '0, '0, r_trd, 1'b1);
                    n_state = S_RESP;
                end else begin
                    n_state = S_TK_SCAN;
                end
            end
            S_TK_SCAN: begin
                if (r_e == (ne - 7'd1)) begin
                    n_state = S_TK_END;
                end
            end
            S_TK_END: n_state = S_TK_DEC;
            S_TK_DEC: begin
                if (!r_pend_v || slot_free) begin
                    // the held rank is last only if this scan found nothing
                    if (r_pend_v) begin
                        out_ld     = 1'b1;
                        out_d      = r_pend;
                        out_d.last = !r_have;
                    end
                    if (r_have) begin
                        div_start = 1'b1;
                        n_state   = S_TK_DIV;
                    end else if (r_pend_v) begin
                        n_state = S_IDLE;
                    end else begin
                        n_res   = mk_res(1'b0, 1'b0, '0, '0, r_total, 1'b1);
                        n_state = S_RESP;
                    end
                end
            end
            S_TK_DIV: begin
                if (div_done) begin
                    if (tk_final) begin
                        n_res   = tk_item;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_TK_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (mass_we) begin
            r_mass_mem[mass_wa] <= mass_wd;
        end
        r_mrd <= r_mass_mem[mass_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tot_we) begin
            r_tot_mem[tot_wa] <= tot_wd;
        end
        r_trd <= r_tot_mem[tot_ra];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_addr        <= '0;
            r_clr_resp    <= 1'b0;
            r_cfg_layers  <= 6'd32;
            r_cfg_experts <= 7'd64;
            r_cfg_decay   <= ONE_Q16;
            r_ovalid      <= 1'b0;
            r_pend_v      <= 1'b0;
            r_have        <= 1'b0;
            r_pv          <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LAYERS:  r_cfg_layers  <= i_cfg_data[5:0];
                    CFG_EXPERTS: r_cfg_experts <= i_cfg_data[6:0];
                    CFG_DECAY:   r_cfg_decay   <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (accept) begin
                r_clr_resp <= (i_in.cmd == CMD_CLEAR);
            end
            if (out_ld) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            r_pv <= (r_state == S_TK_SCAN);
            // running maximum over the scan; lower index wins ties
            if (r_state == S_TK_TOT || (r_state == S_TK_DIV && div_done)) begin
                r_have <= 1'b0;
            end else if (r_pv && !r_sel[r_pe] && (r_mrd != '0) &&
                         (!r_have || (r_mrd > r_best_mass))) begin
                r_have <= 1'b1;
            end
            if (r_state == S_TK_TOT) begin
                r_pend_v <= 1'b0;
            end else if (r_state == S_TK_DEC && (!r_pend_v || slot_free)) begin
                r_pend_v <= 1'b0;
            end else if (r_state == S_TK_DIV && div_done && !tk_final) begin
                r_pend_v <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            r_out <= out_d;
        end
        r_res <= n_res;
        if (accept) begin
            r_layer  <= LW'(i_in.layer);
            r_expert <= EW'(i_in.expert);
            r_weight <= i_in.weight;
            r_kk     <= k_clip;
        end
        r_prod <= r_mrd * {15'd0, r_cfg_decay};
        if (r_state == S_DT_LO) begin
            r_plo <= r_trd[19:0] * r_cfg_decay;
            r_thi <= r_trd[39:20];
        end
        r_phi <= r_thi * r_cfg_decay;
        r_pe  <= r_e[EW-1:0];
        if (r_pv && !r_sel[r_pe] && (r_mrd != '0) &&
            (!r_have || (r_mrd > r_best_mass))) begin
            r_best      <= r_pe;
            r_best_mass <= r_mrd;
        end
        unique case (r_state)
            S_TK_TOT: begin
                r_total <= r_trd;
                r_sel   <= '0;
                r_n     <= '0;
                r_e     <= '0;
            end
            S_TK_SCAN: r_e <= r_e + 7'd1;
            S_TK_DEC: begin
                if (r_have && (!r_pend_v || slot_free)) begin
                    r_sel[r_best] <= 1'b1;
                end
            end
            S_TK_DIV: begin
                if (div_done) begin
                    r_pend <= tk_item;
                    r_n    <= r_n + 7'd1;
                    r_e    <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held top-k rank left behind");
    a_have_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best_mass != '0))
        else $error("selected expert has zero mass");
    a_div_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_DIV) |-> (r_have && (r_n < r_kk)))
        else $error("divide without a selected rank");

endmodule
`default_nettype wire
